/* design/pnoise_pkg.sv */
// Shared types, constants and gradient helper for the octave noise block.
`timescale 1ns / 1ps
package pnoise_pkg;
  localparam int OP_W = 24;
  localparam int PROD_W = 2 * OP_W;
  localparam int FRAC_BITS = 16;
  localparam int PERM_SIZE = 256;
  localparam int PERM_AW = 8;
  localparam int OUT_W = 19;
  localparam int OUT_LIMIT = 131072;
  localparam int PERS_ONE = 65536;

  typedef logic signed [OP_W-1:0] op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic {FUNC_LOAD = 1'b0, FUNC_EVAL = 1'b1} func_t;
  typedef enum logic {CFG_OCTAVES = 1'b0, CFG_PERS = 1'b1} cfg_reg_t;

  localparam op_t ONE_F = op_t'(1 << FRAC_BITS);
  localparam op_t FIFTEEN_F = op_t'(15 << FRAC_BITS);
  localparam op_t TEN_F = op_t'(10 << FRAC_BITS);

  function automatic op_t grad(input logic [1:0] h, input op_t x, input op_t y);
    op_t u;
    op_t v;
    u = h[1] ? y : x;
    v = h[1] ? x : y;
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction
endpackage

/* design/perlin_noise_2d_octaves.sv */
// Top level: 2D gradient noise summed over octaves on one shared multiplier.
//
//  channel | signals                                    | direction
//  item    | start, busy, func, perm_index, perm_value,  | in (busy out)
//          | x_coord, y_coord                           |
//  result  | done, noise_value                          | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | in (ready out)
//
// Load beat: busy stays low. Evaluate beat, per octave: 6 table reads on the
// permutation RAM port, then 16 multiplier steps; after the last octave the
// divider is started on TOT_W quotient bits and its done is registered into
// the done strobe; busy drops as done rises.
// Zero octaves: done follows in the cycle after start. Sync reset restores
// the identity table through per-entry valid bits; done cannot be stalled.
`timescale 1ns / 1ps
module perlin_noise_2d_octaves #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             func,
  input  logic [7:0]                       perm_index,
  input  logic [7:0]                       perm_value,
  input  logic signed [31:0]               x_coord,
  input  logic signed [31:0]               y_coord,
  output logic                             done,
  output logic signed [pnoise_pkg::OUT_W-1:0] noise_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [16:0]                      cfg_data
);
  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam int AS_W = 17 + $clog2(MAX_OCTAVES);
  localparam int TOT_W = 37 + $clog2(MAX_OCTAVES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MATH = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]  state;
  logic [3:0]  step;
  logic [3:0]  octave_count;
  logic [16:0] persistence;
  logic [OW-1:0] oct;
  logic [OW-1:0] oct_n;
  logic [16:0] pers;
  logic [23:0] xs;
  logic [23:0] ys;
  logic [7:0]  hp [6];
  logic [pnoise_pkg::PERM_SIZE-1:0] perm_vld;
  logic        vld_q;
  logic [7:0]  raddr;
  logic [7:0]  raddr_q;
  logic [7:0]  ram_q;
  logic [7:0]  perm_rd;
  logic        ram_we;

  pnoise_pkg::op_t t3;
  pnoise_pkg::op_t fu;
  pnoise_pkg::op_t fv;
  pnoise_pkg::op_t x1;
  pnoise_pkg::op_t x2;
  pnoise_pkg::op_t nz;
  pnoise_pkg::op_t mul_a;
  pnoise_pkg::op_t mul_b;
  pnoise_pkg::op_t ph;
  pnoise_pkg::op_t fx;
  pnoise_pkg::op_t fy;
  pnoise_pkg::op_t fx1;
  pnoise_pkg::op_t fy1;
  pnoise_pkg::op_t g_aa;
  pnoise_pkg::op_t g_ab;
  pnoise_pkg::op_t g_ba;
  pnoise_pkg::op_t g_bb;
  pnoise_pkg::prod_t prod;
  logic [16:0] amp;
  logic [AS_W-1:0] amp_sum;
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] quo;
  logic        div_start;
  logic        div_done;
  logic        accept;
  logic [OW-1:0] n_clamped;

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = start && !busy;
  assign ram_we = accept && (func == pnoise_pkg::FUNC_LOAD);
  assign n_clamped = ({1'b0, octave_count} > 5'(MAX_OCTAVES)) ?
                     OW'(MAX_OCTAVES) : OW'(octave_count);

  assign fx = pnoise_pkg::op_t'({8'd0, xs[15:0]});
  assign fy = pnoise_pkg::op_t'({8'd0, ys[15:0]});
  assign fx1 = fx - pnoise_pkg::ONE_F;
  assign fy1 = fy - pnoise_pkg::ONE_F;
  assign g_aa = pnoise_pkg::grad(hp[2][1:0], fx, fy);
  assign g_ab = pnoise_pkg::grad(hp[3][1:0], fx, fy1);
  assign g_ba = pnoise_pkg::grad(hp[4][1:0], fx1, fy);
  assign g_bb = pnoise_pkg::grad(hp[5][1:0], fx1, fy1);
  assign ph = prod[pnoise_pkg::OP_W+15:16];
  assign perm_rd = vld_q ? ram_q : raddr_q;

  pnoise_ram #(.WIDTH(8), .DEPTH(pnoise_pkg::PERM_SIZE)) u_perm (
    .clk  (clk),
    .we   (ram_we),
    .waddr(perm_index),
    .wdata(perm_value),
    .raddr(raddr),
    .rdata(ram_q)
  );

  pnoise_div #(.NW(TOT_W), .DW(AS_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (total),
    .den  (amp_sum),
    .done (div_done),
    .quo  (quo)
  );

  always_comb begin
    case (step[2:0])
      3'd0: raddr = xs[23:16];
      3'd1: raddr = xs[23:16] + 8'd1;
      3'd2: raddr = hp[0] + ys[23:16];
      3'd3: raddr = hp[0] + ys[23:16] + 8'd1;
      3'd4: raddr = hp[1] + ys[23:16];
      3'd5: raddr = hp[1] + ys[23:16] + 8'd1;
      default: raddr = xs[23:16];
    endcase
  end

  always_comb begin
    mul_a = fx;
    mul_b = fx;
    case (step)
      4'd0: begin
        mul_a = fx;
        mul_b = fx;
      end
      4'd1: begin
        mul_a = ph;
        mul_b = fx;
      end
      4'd2: begin
        mul_a = fx;
        mul_b = (fx <<< 2) + (fx <<< 1) - pnoise_pkg::FIFTEEN_F;
      end
      4'd3: begin
        mul_a = t3;
        mul_b = ph + pnoise_pkg::TEN_F;
      end
      4'd4: begin
        mul_a = fy;
        mul_b = fy;
      end
      4'd5: begin
        mul_a = ph;
        mul_b = fy;
      end
      4'd6: begin
        mul_a = fy;
        mul_b = (fy <<< 2) + (fy <<< 1) - pnoise_pkg::FIFTEEN_F;
      end
      4'd7: begin
        mul_a = t3;
        mul_b = ph + pnoise_pkg::TEN_F;
      end
      4'd8: begin
        mul_a = g_ba - g_aa;
        mul_b = fu;
      end
      4'd9: begin
        mul_a = g_bb - g_ab;
        mul_b = fu;
      end
      4'd11: begin
        mul_a = x2 - x1;
        mul_b = fv;
      end
      4'd13: begin
        mul_a = nz;
        mul_b = pnoise_pkg::op_t'({7'd0, amp});
      end
      4'd14: begin
        mul_a = pnoise_pkg::op_t'({7'd0, amp});
        mul_b = pnoise_pkg::op_t'({7'd0, pers});
      end
      default: begin
        mul_a = fx;
        mul_b = fx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd6;
      persistence <= 17'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pnoise_pkg::CFG_OCTAVES: octave_count <= cfg_data[3:0];
        pnoise_pkg::CFG_PERS:    persistence <= cfg_data;
        default:                 persistence <= persistence;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_vld <= '0;
    end else if (ram_we) begin
      perm_vld[perm_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    vld_q <= perm_vld[raddr];
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      done <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && func != pnoise_pkg::FUNC_LOAD) begin
            step <= '0;
            if (n_clamped == '0) begin
              done <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (step == 4'd6) begin
            step <= '0;
            state <= S_MATH;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_MATH: begin
          step <= step + 4'd1;
          if (step == 4'd15) begin
            if (oct + 1'b1 == oct_n) begin
              state <= S_DIV;
              div_start <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xs <= x_coord[23:0];
      ys <= y_coord[23:0];
      oct <= '0;
      oct_n <= n_clamped;
      pers <= (persistence > 17'(pnoise_pkg::PERS_ONE)) ?
              17'(pnoise_pkg::PERS_ONE) : persistence;
      amp <= 17'(pnoise_pkg::PERS_ONE);
      amp_sum <= '0;
      total <= '0;
      noise_value <= '0;
    end
    if (state == S_READ && step != 4'd0) begin
      hp[step[2:0] - 3'd1] <= perm_rd;
    end
    if (state == S_MATH) begin
      case (step)
        4'd2:  t3 <= ph;
        4'd4:  fu <= ph;
        4'd6:  t3 <= ph;
        4'd8:  fv <= ph;
        4'd9:  x1 <= g_aa + ph;
        4'd10: x2 <= g_ab + ph;
        4'd12: nz <= x1 + ph;
        4'd14: begin
          total <= total + prod[TOT_W-1:0];
          amp_sum <= amp_sum + AS_W'(amp);
        end
        4'd15: begin
          amp <= prod[32:16];
          xs <= {xs[22:0], 1'b0};
          ys <= {ys[22:0], 1'b0};
          oct <= oct + 1'b1;
        end
        default: nz <= nz;
      endcase
    end
    if (state == S_DIV && div_done) begin
      if (quo > TOT_W'(pnoise_pkg::OUT_LIMIT)) begin
        noise_value <= pnoise_pkg::OUT_W'(pnoise_pkg::OUT_LIMIT);
      end else if (quo < -TOT_W'(pnoise_pkg::OUT_LIMIT)) begin
        noise_value <= -pnoise_pkg::OUT_W'(pnoise_pkg::OUT_LIMIT);
      end else begin
        noise_value <= quo[pnoise_pkg::OUT_W-1:0];
      end
    end
  end
endmodule

/* design/pnoise_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pnoise_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/pnoise_div.sv */
// Restoring divider, one quotient bit per cycle, truncates toward zero.
`timescale 1ns / 1ps
module pnoise_div #(
  parameter int NW = 40,
  parameter int DW = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic          active;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [NW-1:0] q;
  logic          neg;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem, q[NW-1]};
  assign diff = shifted - {1'b0, dsr};
  assign quo = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt <= CW'(NW);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[NW-1];
      q <= num[NW-1] ? NW'(-num) : NW'(num);
      rem <= '0;
      dsr <= den;
    end else if (active) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

/* sim/testbench.sv */
// Testbench for the octave gradient noise block: directed table, random beats, own predictor.
`timescale 1ns / 1ps
module testbench;
  typedef struct {
    pnoise_pkg::func_t fn;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [31:0] x;
    logic [31:0] y;
    bit          fixed;
    int          want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic func = 1'b0;
  logic [7:0] perm_index = '0;
  logic [7:0] perm_value = '0;
  logic signed [31:0] x_coord = '0;
  logic signed [31:0] y_coord = '0;
  logic done;
  logic signed [pnoise_pkg::OUT_W-1:0] noise_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [16:0] cfg_data = '0;

  perlin_noise_2d_octaves dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0]  model_perm [pnoise_pkg::PERM_SIZE];
  logic [3:0]  model_octaves;
  logic [16:0] model_persist;
  logic signed [pnoise_pkg::OUT_W-1:0] noise_due [$];
  int errors = 0;
  int n_eval = 0;
  int n_load = 0;
  int n_seen = 0;
  bit calm = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint fade_q(input longint t);
    longint t2, t3, p;
    t2 = (t * t) >>> pnoise_pkg::FRAC_BITS;
    t3 = (t2 * t) >>> pnoise_pkg::FRAC_BITS;
    p = ((t * (6 * t - 15 * 65536)) >>> pnoise_pkg::FRAC_BITS) + 10 * 65536;
    return (t3 * p) >>> pnoise_pkg::FRAC_BITS;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint t);
    return a + (((b - a) * t) >>> pnoise_pkg::FRAC_BITS);
  endfunction

  function automatic longint slope(input logic [7:0] h, input longint x, input longint y);
    longint u, v;
    u = h[1] ? y : x;
    v = h[1] ? x : y;
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint lattice_noise(input logic [63:0] ux, input logic [63:0] uy,
                                           input int sh);
    logic [63:0] xs, ys;
    logic [7:0] cx, cy, p0, p1, aa, ab, ba, bb;
    longint fx, fy, u, v, x1, x2;
    xs = ux << sh;
    ys = uy << sh;
    cx = xs[23:16];
    cy = ys[23:16];
    fx = longint'(xs[15:0]);
    fy = longint'(ys[15:0]);
    u = fade_q(fx);
    v = fade_q(fy);
    p0 = model_perm[cx];
    p1 = model_perm[8'(cx + 8'd1)];
    aa = model_perm[8'(p0 + cy)];
    ab = model_perm[8'(p0 + cy + 8'd1)];
    ba = model_perm[8'(p1 + cy)];
    bb = model_perm[8'(p1 + cy + 8'd1)];
    x1 = blend(slope(aa, fx, fy), slope(ba, fx - 65536, fy), u);
    x2 = blend(slope(ab, fx, fy - 65536), slope(bb, fx - 65536, fy - 65536), u);
    return blend(x1, x2, v);
  endfunction

  function automatic logic signed [pnoise_pkg::OUT_W-1:0] octave_noise(
    input logic [31:0] x, input logic [31:0] y);
    int n;
    longint total, amp_sum, amp, pers, q;
    logic [63:0] ux, uy;
    n = (model_octaves > 8) ? 8 : model_octaves;
    if (n == 0) return '0;
    pers = (model_persist > 17'd65536) ? 65536 : longint'(model_persist);
    ux = {{32{x[31]}}, x};
    uy = {{32{y[31]}}, y};
    total = 0;
    amp_sum = 0;
    amp = 65536;
    for (int i = 0; i < n; i++) begin
      total += lattice_noise(ux, uy, i) * amp;
      amp_sum += amp;
      amp = (amp * pers) >>> 16;
    end
    q = total / amp_sum;
    if (q > pnoise_pkg::OUT_LIMIT) q = pnoise_pkg::OUT_LIMIT;
    if (q < -pnoise_pkg::OUT_LIMIT) q = -pnoise_pkg::OUT_LIMIT;
    return q[pnoise_pkg::OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      n_seen++;
      if (noise_due.size() == 0) report("unexpected result", noise_value, 0);
      else begin
        if (noise_value !== noise_due[0]) report("noise_value", noise_value, noise_due[0]);
        void'(noise_due.pop_front());
      end
    end
  end

  task automatic send_beat(input row_t r);
    if (!calm && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    start <= 1'b1;
    func <= r.fn;
    perm_index <= r.idx;
    perm_value <= r.val;
    x_coord <= r.x;
    y_coord <= r.y;
    do @(posedge clk); while (busy);
    if (r.fn == pnoise_pkg::FUNC_LOAD) begin
      model_perm[r.idx] = r.val;
      n_load++;
    end else begin
      n_eval++;
      if (r.fixed) noise_due.push_back(pnoise_pkg::OUT_W'(r.want));
      else noise_due.push_back(octave_noise(r.x, r.y));
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (noise_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input pnoise_pkg::cfg_reg_t idx, input logic [16:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pnoise_pkg::CFG_OCTAVES) model_octaves = data[3:0];
    else model_persist = data;
  endtask

  function automatic row_t rand_row();
    row_t r;
    r.fixed = 1'b0;
    r.want = 0;
    r.fn = ($urandom_range(99) < 25) ? pnoise_pkg::FUNC_LOAD : pnoise_pkg::FUNC_EVAL;
    r.idx = 8'($urandom);
    r.val = 8'($urandom);
    case ($urandom_range(3))
      0: begin
        r.x = $urandom;
        r.y = $urandom;
      end
      1: begin
        r.x = 32'($signed($urandom_range(2097152)) - 1048576);
        r.y = 32'($signed($urandom_range(2097152)) - 1048576);
      end
      2: begin
        r.x = {$urandom_range(255) > 127 ? 16'hFFFF : 16'h0000, 16'($urandom)};
        r.y = {16'($urandom), 16'($urandom)};
      end
      default: begin
        r.x = {16'($urandom), 16'h0000};
        r.y = {16'($urandom), $urandom_range(1) ? 16'hFFFF : 16'h0001};
      end
    endcase
    return r;
  endfunction

  row_t plan [] = '{
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 0},
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, 0},
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'h7FFF_0000, 32'hFFFF_0000, 1'b1, 0},
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 0},
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 0},
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'h0000_8000, 32'h0000_8000, 1'b0, 0},
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'h8000_FFFF, 32'h5555_AAAA, 1'b0, 0},
    '{pnoise_pkg::FUNC_LOAD, 8'd0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0},
    '{pnoise_pkg::FUNC_LOAD, 8'd255, 8'd0, 32'h0, 32'h0, 1'b0, 0},
    '{pnoise_pkg::FUNC_LOAD, 8'hAA, 8'h55, 32'h0, 32'h0, 1'b0, 0},
    '{pnoise_pkg::FUNC_LOAD, 8'h55, 8'hAA, 32'h0, 32'h0, 1'b0, 0},
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'h00FF_C000, 32'h0000_4000, 1'b0, 0},
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'hFF00_1234, 32'h00FF_F000, 1'b0, 0},
    '{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 0}
  };

  initial begin
    for (int i = 0; i < pnoise_pkg::PERM_SIZE; i++) model_perm[i] = 8'(i);
    model_octaves = 4'd6;
    model_persist = 17'd32768;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[i]) send_beat(plan[i]);
    write_reg(pnoise_pkg::CFG_OCTAVES, 17'd0);
    send_beat('{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'h1234_5678, 32'h8765_4321, 1'b1, 0});
    send_beat('{pnoise_pkg::FUNC_EVAL, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 0});
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(pnoise_pkg::CFG_OCTAVES, 17'd8);
          write_reg(pnoise_pkg::CFG_PERS, 17'd65536);
        end
        1: begin
          write_reg(pnoise_pkg::CFG_OCTAVES, 17'h1FFFF);
          write_reg(pnoise_pkg::CFG_PERS, 17'h1FFFF);
        end
        2: begin
          write_reg(pnoise_pkg::CFG_OCTAVES, 17'd1);
          write_reg(pnoise_pkg::CFG_PERS, 17'd0);
        end
        3: begin
          write_reg(pnoise_pkg::CFG_OCTAVES, 17'd3);
          write_reg(pnoise_pkg::CFG_PERS, 17'h0AAAA);
        end
        4: begin
          write_reg(pnoise_pkg::CFG_OCTAVES, 17'h10009);
          write_reg(pnoise_pkg::CFG_PERS, 17'h15555);
        end
        5: begin
          write_reg(pnoise_pkg::CFG_OCTAVES, 17'd0);
          write_reg(pnoise_pkg::CFG_PERS, 17'd1);
        end
        default: begin
          write_reg(pnoise_pkg::CFG_OCTAVES, 17'd6);
          write_reg(pnoise_pkg::CFG_PERS, 17'd32768);
        end
      endcase
      calm = (ph == 3);
      for (int k = 0; k < 72; k++) begin
        if (ph == 2 && k == 30) drain();
        send_beat(rand_row());
      end
    end
    calm = 1'b0;
    drain();
    repeat (400) @(posedge clk);
    $display("Covered %0d evaluate and %0d table load beats, %0d results checked,",
             n_eval, n_load, n_seen);
    $display("over eight octave/persistence settings including both register extremes.");
    if (errors == 0) $display("perlin_noise_2d_octaves test passed");
    else $display("perlin_noise_2d_octaves test failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("perlin_noise_2d_octaves test failed");
    $finish;
  end
endmodule

/* sim.f */
design/pnoise_pkg.sv
design/pnoise_ram.sv
design/pnoise_div.sv
design/perlin_noise_2d_octaves.sv
sim/testbench.sv
